// ----- sv/hdce_pkg.sv -----
package hdce_pkg;

    localparam int unsigned KindW   = 3;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned HTensW  = 2;
    localparam int unsigned DigitW  = 4;
    localparam int unsigned MTensW  = 3;
    localparam int unsigned CursorW = 2;

    localparam logic [ByteW-1:0] MaxHour   = 8'd23;
    localparam logic [ByteW-1:0] MaxMinute = 8'd59;

    // Digit positions under the cursor
    localparam logic [CursorW-1:0] POS_HTENS  = 2'd0;
    localparam logic [CursorW-1:0] POS_HUNITS = 2'd1;
    localparam logic [CursorW-1:0] POS_MTENS  = 2'd2;
    localparam logic [CursorW-1:0] POS_MUNITS = 2'd3;

    // Per-digit limits
    localparam logic [DigitW-1:0] LIM_HTENS     = 4'd2;
    localparam logic [DigitW-1:0] LIM_HUNITS_20 = 4'd3;
    localparam logic [DigitW-1:0] LIM_UNITS     = 4'd9;
    localparam logic [DigitW-1:0] LIM_MTENS     = 4'd5;

    typedef enum logic [KindW-1:0] {
        KIND_LEFT  = 3'd0,
        KIND_RIGHT = 3'd1,
        KIND_INC   = 3'd2,
        KIND_DEC   = 3'd3,
        KIND_SET   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [HTensW-1:0] ht;
        logic [DigitW-1:0] hu;
        logic [MTensW-1:0] mt;
        logic [DigitW-1:0] mu;
    } t_time;

    typedef struct packed {
        t_time              tm;
        logic [CursorW-1:0] cursor;
        logic               accepted;
        logic [DigitW-1:0]  limit;
    } t_edit_res;

endpackage

// ----- sv/hdce_if.sv -----
interface hdce_in_if;
    logic                           valid;
    logic                           ready;
    logic [hdce_pkg::KindW-1:0]     kind;
    logic [hdce_pkg::ByteW-1:0]     new_hours;
    logic [hdce_pkg::ByteW-1:0]     new_minutes;

    modport source (output valid, kind, new_hours, new_minutes, input ready);
    modport sink   (input valid, kind, new_hours, new_minutes, output ready);
endinterface

interface hdce_out_if;
    logic                           valid;
    logic                           ready;
    logic [hdce_pkg::HTensW-1:0]    hour_tens;
    logic [hdce_pkg::DigitW-1:0]    hour_units;
    logic [hdce_pkg::MTensW-1:0]    minute_tens;
    logic [hdce_pkg::DigitW-1:0]    minute_units;
    logic [hdce_pkg::CursorW-1:0]   cursor_digit;
    logic                           accepted;
    logic [hdce_pkg::DigitW-1:0]    digit_limit;

    modport source (output valid, hour_tens, hour_units, minute_tens, minute_units,
                    cursor_digit, accepted, digit_limit, input ready);
    modport sink   (input valid, hour_tens, hour_units, minute_tens, minute_units,
                    cursor_digit, accepted, digit_limit, output ready);
endinterface

// ----- sv/hdce_split.sv -----
// Split a value below 60 into tens and units by a row of compares.
module hdce_split (
    input  logic [5:0]                  i_value,
    output logic [hdce_pkg::MTensW-1:0] o_tens,
    output logic [hdce_pkg::DigitW-1:0] o_units
);
    import hdce_pkg::*;

    logic [MTensW-1:0] tens;
    logic [6:0]        base;

    always_comb begin
        tens = '0;
        for (int k = 1; k <= 5; k++) begin
            if (i_value >= 6'(k * 10)) begin
                tens = MTensW'(k);
            end
        end
        base    = 7'(tens) * 7'd10;
        o_tens  = tens;
        o_units = DigitW'(7'(i_value) - base);
    end
endmodule

// ----- sv/hdce_edit.sv -----
// Next state of the time digits and cursor for one event.
module hdce_edit (
    input  hdce_pkg::t_time               i_tm,
    input  logic [hdce_pkg::CursorW-1:0]  i_cursor,
    input  logic [hdce_pkg::KindW-1:0]    i_kind,
    input  hdce_pkg::t_time               i_set_tm,
    input  logic                          i_set_ok,
    output hdce_pkg::t_edit_res           o_res
);
    import hdce_pkg::*;

    t_time              tm;
    logic [CursorW-1:0] cur;
    logic               acc;
    logic [DigitW-1:0]  d;
    logic [DigitW-1:0]  lim;
    logic [DigitW-1:0]  nd;

    function automatic logic [DigitW-1:0] limit_at(logic [CursorW-1:0] pos,
                                                   logic [HTensW-1:0] ht);
        logic [DigitW-1:0] l;
        unique case (pos)
            POS_HTENS:  l = LIM_HTENS;
            POS_HUNITS: l = (ht == 2'd2) ? LIM_HUNITS_20 : LIM_UNITS;
            POS_MTENS:  l = LIM_MTENS;
            default:    l = LIM_UNITS;
        endcase
        return l;
    endfunction

    always_comb begin
        tm  = i_tm;
        cur = i_cursor;
        acc = 1'b1;

        // digit under the cursor and its limit
        unique case (i_cursor)
            POS_HTENS:  d = DigitW'(i_tm.ht);
            POS_HUNITS: d = i_tm.hu;
            POS_MTENS:  d = DigitW'(i_tm.mt);
            default:    d = i_tm.mu;
        endcase
        lim = limit_at(i_cursor, i_tm.ht);

        if (i_kind == KIND_INC) begin
            nd = (d >= lim) ? '0 : d + 4'd1;
        end else begin
            nd = (d == '0 || d > lim) ? lim : d - 4'd1;
        end

        unique case (i_kind)
            KIND_LEFT:  cur = i_cursor - 2'd1;
            KIND_RIGHT: cur = i_cursor + 2'd1;
            KIND_INC, KIND_DEC: begin
                unique case (i_cursor)
                    POS_HTENS:  tm.ht = HTensW'(nd);
                    POS_HUNITS: tm.hu = nd;
                    POS_MTENS:  tm.mt = MTensW'(nd);
                    default:    tm.mu = nd;
                endcase
                // hold hours at or below 23
                if (tm.ht == 2'd2 && tm.hu > 4'd3) begin
                    tm.hu = 4'd3;
                end
            end
            KIND_SET: begin
                if (i_set_ok) begin
                    tm = i_set_tm;
                end else begin
                    acc = 1'b0;
                end
            end
            default: ;
        endcase

        o_res.tm       = tm;
        o_res.cursor   = cur;
        o_res.accepted = acc;
        o_res.limit    = limit_at(cur, tm.ht);
    end
endmodule

// ----- sv/hhmm_digit_cursor_editor.sv -----
// Each result is registered: it appears on the output in the cycle after its input transfer.
// Throughput: one event per cycle; the input is ready whenever the output
// register is empty or its result transfers in the same cycle.
// Reset (synchronous, active low): time 10:00, cursor on the hour tens digit,
// no result pending.
module hhmm_digit_cursor_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hdce_in_if.sink    i_evt,
    hdce_out_if.source o_res
);
    import hdce_pkg::*;

    // Time state is kept as four BCD digits so that every edit works on a
    // digit directly and no divide is needed on the result side.
    t_time              r_time,   n_time;
    logic [CursorW-1:0] r_cursor, n_cursor;
    logic               r_valid,  n_valid;
    logic               r_acc,    n_acc;
    logic [DigitW-1:0]  r_limit,  n_limit;

    logic              take;
    logic              set_ok;
    t_time             set_tm;
    logic [MTensW-1:0] set_htens;
    t_edit_res         edit_res;

    // Accept a new event whenever the result slot is free or drains now.
    assign i_evt.ready = ~r_valid | o_res.ready;
    assign take        = i_evt.valid & i_evt.ready;

    // Set-time range check; digit split only matters when in range.
    assign set_ok = (i_evt.new_hours <= MaxHour) && (i_evt.new_minutes <= MaxMinute);

    hdce_split u_split_hours (
        .i_value (i_evt.new_hours[5:0]),
        .o_tens  (set_htens),
        .o_units (set_tm.hu)
    );

    hdce_split u_split_minutes (
        .i_value (i_evt.new_minutes[5:0]),
        .o_tens  (set_tm.mt),
        .o_units (set_tm.mu)
    );

    assign set_tm.ht = set_htens[HTensW-1:0];

    hdce_edit u_edit (
        .i_tm     (r_time),
        .i_cursor (r_cursor),
        .i_kind   (i_evt.kind),
        .i_set_tm (set_tm),
        .i_set_ok (set_ok),
        .o_res    (edit_res)
    );

    always_comb begin
        n_time   = r_time;
        n_cursor = r_cursor;
        n_acc    = r_acc;
        n_limit  = r_limit;
        n_valid  = r_valid & ~o_res.ready;
        if (take) begin
            // advance state and load the result register together
            n_time   = edit_res.tm;
            n_cursor = edit_res.cursor;
            n_acc    = edit_res.accepted;
            n_limit  = edit_res.limit;
            n_valid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time   <= '{ht: 2'd1, hu: 4'd0, mt: 3'd0, mu: 4'd0};
            r_cursor <= POS_HTENS;
            r_valid  <= 1'b0;
        end else begin
            r_time   <= n_time;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
        end
    end

    // Result payload; held while the output is stalled.
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_limit <= n_limit;
    end

    // The state registers double as the digit fields of the pending result:
    // they change only on an input transfer, which also refills the slot.
    assign o_res.valid        = r_valid;
    assign o_res.hour_tens    = r_time.ht;
    assign o_res.hour_units   = r_time.hu;
    assign o_res.minute_tens  = r_time.mt;
    assign o_res.minute_units = r_time.mu;
    assign o_res.cursor_digit = r_cursor;
    assign o_res.accepted     = r_acc;
    assign o_res.digit_limit  = r_limit;

endmodule
